>>> sv/first_substring_match_finder_unit_macros.svh
// ----------------------------------------------------------------------------
// first substring match finder assertion macros
// implication checks on the rising clock edge, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef FIRST_SUBSTRING_MATCH_FINDER_UNIT_MACROS_SVH
`define FIRST_SUBSTRING_MATCH_FINDER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FSMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FSMF_ASSERT_IMP(lbl, ante, cons, msg)
`define FSMF_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/fsmf_pkg.sv
// ----------------------------------------------------------------------------
// fsmf_pkg
// shared types and constants of the first substring match finder
// ----------------------------------------------------------------------------
`default_nettype none

package fsmf_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 64;
  localparam int unsigned PLenW   = 5;
  localparam int unsigned IndexW  = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } cfg_reg_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             clear;
    logic             step;
    logic [CharW-1:0] text_char;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/fsmf_cell.sv
// ----------------------------------------------------------------------------
// fsmf_cell
// one pattern position: holds its pattern character and partial-match bit
// ----------------------------------------------------------------------------
`default_nettype none

module fsmf_cell
  import fsmf_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic             pat_we_i,
  input  wire logic [CharW-1:0] pat_byte_i,
  input  wire logic [PLenW-1:0] plen_i,
  input  wire logic             prev_match_i,
  input  wire logic             active_i,
  input  wire logic             active_next_i,
  output logic                  match_o,
  output logic                  active_o,
  output logic                  last_o,
  output logic                  hit_o
);

  logic [CharW-1:0] pat_q;
  logic             match_q;
  logic             match_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
    end else if (pat_we_i) begin
      pat_q <= pat_byte_i;
    end
  end

  // position is in use when inside the length and no zero byte at or before it
  assign active_o = active_i && (PLenW'(CELL_IDX) < plen_i) && (pat_q != '0);
  assign last_o   = active_o && !active_next_i;

  assign match_d = prev_match_i && active_o && (ctrl_i.text_char == pat_q);
  assign hit_o   = last_o && match_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      match_q <= 1'b0;
    end else if (ctrl_i.step) begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule

`default_nettype wire

>>> sv/first_substring_match_finder_unit.sv
// ----------------------------------------------------------------------------
// first_substring_match_finder_unit
// streaming substring search: a row of cells, one per pattern character
// ----------------------------------------------------------------------------
// throughput: one text word per cycle, but a terminator waits while a result is held at the output
// the result word is valid in the cycle after the terminator is taken
// non-terminator words are taken even while a result waits at the output
// reset: search state, pattern, length and output valid all clear to zero
// the search state also clears after every terminator
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_substring_match_finder_unit_macros.svh"

module first_substring_match_finder_unit
  import fsmf_pkg::*;
#(
  parameter int unsigned MAX_PATTERN   = 16,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDatW-1:0]  cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [CharW-1:0]    text_char_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [IndexW-1:0] match_index_o,
  output logic                     overflow_o
);

  localparam int unsigned IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned ExtW = (POSITION_BITS > IndexW) ? POSITION_BITS : IndexW;
  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

  logic [PLenW-1:0]         plen_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] first_start_q;
  logic [POSITION_BITS-1:0] first_start_d;
  logic                     found_q;
  logic                     sat_q;
  logic                     out_valid_q;
  logic [IndexW-1:0]        index_q;
  logic                     ovf_q;

  logic                     in_acc;
  logic                     term_acc;
  logic                     char_acc;
  logic                     any_hit;
  logic [IdxW-1:0]          last_idx;
  logic [ExtW-1:0]          start_ext;
  cell_ctrl_t               ctrl;

  logic [MAX_PATTERN-1:0]   match_vec;
  logic [MAX_PATTERN-1:0]   active_vec;
  logic [MAX_PATTERN-1:0]   last_vec;
  logic [MAX_PATTERN-1:0]   hit_vec;

  // a terminator needs the output slot, other words never do
  assign in_ready_o = !out_valid_q || out_ready_i || (text_char_i != '0);
  assign in_acc     = in_valid_i && in_ready_o;
  assign term_acc   = in_acc && (text_char_i == '0);
  assign char_acc   = in_acc && (text_char_i != '0) && !sat_q;

  assign ctrl.clear     = term_acc;
  assign ctrl.step      = char_acc && !found_q && active_vec[0];
  assign ctrl.text_char = text_char_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
    end else if (cfg_we_i && (cfg_index_i == CFG_PAT_LEN)) begin
      plen_q <= cfg_data_i[PLenW-1:0];
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    localparam int unsigned Lane = k % 8;
    logic pat_we;
    logic prev_match;
    logic active_in;
    logic active_next;

    if (k < 8) begin : g_low
      assign pat_we = cfg_we_i && (cfg_index_i == CFG_PAT_LOW);
    end else begin : g_high
      assign pat_we = cfg_we_i && (cfg_index_i == CFG_PAT_HIGH);
    end

    if (k == 0) begin : g_head
      assign prev_match = 1'b1;
      assign active_in  = 1'b1;
    end else begin : g_body
      assign prev_match = match_vec[k-1];
      assign active_in  = active_vec[k-1];
    end

    if (k == MAX_PATTERN - 1) begin : g_tail
      assign active_next = 1'b0;
    end else begin : g_mid
      assign active_next = active_vec[k+1];
    end

    fsmf_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .pat_we_i      (pat_we),
      .pat_byte_i    (cfg_data_i[8*Lane +: 8]),
      .plen_i        (plen_q),
      .prev_match_i  (prev_match),
      .active_i      (active_in),
      .active_next_i (active_next),
      .match_o       (match_vec[k]),
      .active_o      (active_vec[k]),
      .last_o        (last_vec[k]),
      .hit_o         (hit_vec[k])
    );
  end

  assign any_hit = |hit_vec;

  always_comb begin
    last_idx = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (last_vec[k]) begin
        last_idx = last_idx | IdxW'(k);
      end
    end
  end

  assign first_start_d = pos_q - POSITION_BITS'(last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      sat_q         <= 1'b0;
      found_q       <= 1'b0;
      first_start_q <= '0;
    end else if (term_acc) begin
      pos_q         <= '0;
      sat_q         <= 1'b0;
      found_q       <= 1'b0;
      first_start_q <= '0;
    end else if (char_acc) begin
      if (ctrl.step && any_hit) begin
        found_q       <= 1'b1;
        first_start_q <= first_start_d;
      end
      if (pos_q == PosMax) begin
        sat_q <= 1'b1;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  assign start_ext = ExtW'(first_start_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (term_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (term_acc) begin
      if (!active_vec[0]) begin
        index_q <= '0;
        ovf_q   <= 1'b0;
      end else if (found_q) begin
        index_q <= start_ext[IndexW-1:0];
        ovf_q   <= 1'b0;
      end else begin
        index_q <= '1;
        ovf_q   <= sat_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_index_o = index_q;
  assign overflow_o    = ovf_q;

  `FSMF_ASSERT_NXT(a_clear_after_term, term_acc,
                   (pos_q == '0) && !found_q && !sat_q && (match_vec == '0),
                   "search state not cleared after terminator")
  `FSMF_ASSERT_IMP(a_sat_pos_max, sat_q, pos_q == PosMax,
                   "saturated without counter at maximum")
  `FSMF_ASSERT_NXT(a_start_held, found_q && !term_acc, $stable(first_start_q),
                   "first start changed after a match")
  `FSMF_ASSERT_IMP(a_ovf_not_found, out_valid_q && ovf_q, index_q == '1,
                   "overflow raised with a found index")

endmodule

`default_nettype wire

>>> tb/first_substring_match_finder_unit_tb.sv
// ----------------------------------------------------------------------------
// first_substring_match_finder_unit_tb
// streams texts through the finder and checks each first-match word against a
// local search predictor, first from a short table whose typed rows give the
// expected word, then over random patterns and random texts
// ----------------------------------------------------------------------------
module first_substring_match_finder_unit_tb;
  import fsmf_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam logic signed [IndexW-1:0] NoMatch = -1;

  typedef struct packed {
    logic signed [IndexW-1:0] pos;
    logic                     ovf;
  } hit_t;

  typedef enum logic {ROW_REG, ROW_CHAR} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    cfg_reg_e                 reg_idx;
    logic [CfgDatW-1:0]       value;
    logic                     typed;
    logic signed [IndexW-1:0] want_pos;
    logic                     want_ovf;
  } step_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDatW-1:0] cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [CharW-1:0]   text_char_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [IndexW-1:0] match_index_o;
  logic               overflow_o;

  // predictor copy of the registers and the search state
  logic [CfgDatW-1:0] pat_lo_q  = '0;
  logic [CfgDatW-1:0] pat_hi_q  = '0;
  logic [PLenW-1:0]   pat_len_q = '0;
  logic [15:0]        srch_vec   = '0;
  logic [15:0]        srch_pos   = '0;
  logic               srch_found = 1'b0;
  logic [15:0]        srch_start = '0;
  logic               srch_sat   = 1'b0;

  hit_t pending_hits [$];
  hit_t head_hit;
  bit   idle_on    = 1'b0;
  int   stall_left = 0;
  int   err_count  = 0;
  int   cycles     = 0;
  int   sent       = 0;

  step_row_t dir_tab [26] = '{
    // empty pattern after reset, on empty and on non-empty text
    '{ROW_CHAR, CFG_PAT_LOW, 64'h00, 1'b1, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'h71, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'h00, 1'b1, 17'sd0, 1'b0},
    // pattern "abc"
    '{ROW_REG,  CFG_PAT_LOW, 64'h636261, 1'b0, 17'sd0, 1'b0},
    '{ROW_REG,  CFG_PAT_LEN, 64'd3, 1'b0, 17'sd0, 1'b0},
    // empty text, non-empty pattern
    '{ROW_CHAR, CFG_PAT_LOW, 64'h00, 1'b1, NoMatch, 1'b0},
    // "aabc": prefix broken and restarted
    '{ROW_CHAR, CFG_PAT_LOW, 64'h61, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'h61, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'h62, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'h63, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'h00, 1'b0, 17'sd0, 1'b0},
    // only a prefix before the end of the text
    '{ROW_CHAR, CFG_PAT_LOW, 64'h61, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'h62, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'h00, 1'b1, NoMatch, 1'b0},
    // all-ones low half, zero high half cuts the pattern at 8, length at max
    '{ROW_REG,  CFG_PAT_LOW,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 17'sd0, 1'b0},
    '{ROW_REG,  CFG_PAT_HIGH, 64'h0, 1'b0, 17'sd0, 1'b0},
    '{ROW_REG,  CFG_PAT_LEN,  64'd31, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'hFF, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'hFF, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'hFF, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'hFF, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'hFF, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'hFF, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'hFF, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'hFF, 1'b0, 17'sd0, 1'b0},
    '{ROW_CHAR, CFG_PAT_LOW, 64'h00, 1'b1, 17'sd0, 1'b0}
  };

  first_substring_match_finder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_char_i   (text_char_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .match_index_o (match_index_o),
    .overflow_o    (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // one text word through the search; returns 1 when it yields a result
  function automatic bit predict_search(input logic [CharW-1:0] c, output hit_t hit);
    logic [127:0] pat;
    logic [15:0]  eq;
    int           eff;
    pat = {pat_hi_q, pat_lo_q};
    eff = (pat_len_q > 16) ? 16 : int'(pat_len_q);
    // the first zero byte ends the pattern early
    for (int k = 15; k >= 0; k--)
      if (k < eff && pat[8*k +: 8] == 8'h00) eff = k;
    hit = '0;
    if (c == 8'h00) begin
      if (eff == 0) begin
        hit.pos = '0;
      end else if (srch_found) begin
        hit.pos = {1'b0, srch_start};
      end else begin
        hit.pos = NoMatch;
        hit.ovf = srch_sat;
      end
      srch_vec   = '0;
      srch_pos   = '0;
      srch_found = 1'b0;
      srch_start = '0;
      srch_sat   = 1'b0;
      return 1'b1;
    end
    if (!srch_sat) begin
      if (!srch_found && eff != 0) begin
        eq = '0;
        for (int k = 0; k < 16; k++)
          if (k < eff && pat[8*k +: 8] == c) eq[k] = 1'b1;
        srch_vec = {srch_vec[14:0], 1'b1} & eq;
        if (srch_vec[eff-1]) begin
          srch_found = 1'b1;
          srch_start = srch_pos - 16'(eff - 1);
        end
      end
      if (srch_pos == 16'hFFFF) srch_sat = 1'b1;
      else srch_pos = srch_pos + 16'd1;
    end
    return 1'b0;
  endfunction

  task automatic send_char(input logic [CharW-1:0] c);
    hit_t hit;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_char_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_search(c, hit)) pending_hits.push_back(hit);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDatW-1:0] d);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PAT_LOW:  pat_lo_q = d;
      CFG_PAT_HIGH: pat_hi_q = d;
      CFG_PAT_LEN:  pat_len_q = d[PLenW-1:0];
      default: ;
    endcase
  endtask

  // new pattern over a small alphabet, then a handful of texts on it
  task automatic run_search_phase(input bit calm);
    logic [CharW-1:0] alpha [4];
    logic [CharW-1:0] pat [16];
    logic [127:0]     pat_word;
    logic [CharW-1:0] c;
    int               asz, plen, tlen, at, kind;
    bit               ones;
    asz  = $urandom_range(1, 4);
    ones = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < 4; i++) begin
      if (ones) alpha[i] = 8'hFF;
      else if ($urandom_range(0, 5) == 0) alpha[i] = 8'($urandom_range(1, 255));
      else alpha[i] = 8'h61 + 8'(i);
    end
    for (int k = 0; k < 16; k++) begin
      if (ones) pat[k] = 8'hFF;
      else if ($urandom_range(0, 15) == 0) pat[k] = 8'($urandom_range(1, 255));
      else pat[k] = alpha[$urandom_range(0, asz - 1)];
    end
    if (!ones && $urandom_range(0, 7) == 0) pat[$urandom_range(0, 15)] = 8'h00;
    case ($urandom_range(0, 11))
      0:       plen = 0;
      1, 2:    plen = 16;
      3:       plen = $urandom_range(17, 31);
      default: plen = $urandom_range(1, 6);
    endcase
    for (int k = 0; k < 16; k++) pat_word[8*k +: 8] = pat[k];

    wait_drained();
    write_reg(CFG_PAT_LOW, pat_word[63:0]);
    write_reg(CFG_PAT_HIGH, pat_word[127:64]);
    write_reg(CFG_PAT_LEN, 64'(plen));
    idle_on = !calm && ($urandom_range(0, 3) != 0);

    repeat ($urandom_range(3, 8)) begin
      tlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 30);
      kind = $urandom_range(0, 9);
      at   = $urandom_range(0, tlen);
      for (int p = 0; p < tlen; p++) begin
        // mostly a planted copy of the pattern, some texts pure noise
        if (kind == 9) c = 8'($urandom_range(1, 255));
        else if (kind < 7 && p >= at && p - at < 16 && pat[p-at] != 8'h00) c = pat[p-at];
        else c = alpha[$urandom_range(0, asz - 1)];
        send_char(c);
        sent++;
      end
      send_char(8'h00);
      sent++;
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hits.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result word: match_index %0d overflow %0b",
                   match_index_o, overflow_o);
      end else begin
        head_hit = pending_hits.pop_front();
        if (match_index_o !== head_hit.pos || overflow_o !== head_hit.ovf) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: match_index exp %0d got %0d, overflow exp %0b got %0b",
                     $signed(head_hit.pos), match_index_o, head_hit.ovf, overflow_o);
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** first_substring_match_finder_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
      end else begin
        send_char(dir_tab[i].value[CharW-1:0]);
        if (dir_tab[i].typed)
          pending_hits[pending_hits.size()-1] = '{pos: dir_tab[i].want_pos,
                                                  ovf: dir_tab[i].want_ovf};
      end
    end

    while (sent < 850) run_search_phase(1'b0);

    // calm tail: no idling on either side
    wait_drained();
    idle_on = 1'b0;

    while (sent < 1050) run_search_phase(1'b1);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) $display("** first_substring_match_finder_unit: PASSED **");
    else $display("** first_substring_match_finder_unit: FAILED **");
    $finish;
  end

endmodule
